@@ hdl/stk_pkg.sv @@
// ============================================================================
// stk_pkg
// Shared types and constants for the trajectory smoother.
// ============================================================================
`default_nettype none
package stk_pkg;
  localparam int PATH_WIDTH = 48;
  localparam int CORDIC_STEPS = 30;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] PROCESS_NOISE_RST = 32'd4294967;
  localparam logic [31:0] MEASUREMENT_NOISE_RST = 32'd268435456;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [0:0] REG_PROCESS_NOISE = 1'b0;
  localparam logic [0:0] REG_MEASUREMENT_NOISE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PATH, ST_PREP, ST_DIV, ST_UPD, ST_VAR, ST_CORR, ST_CORDIC, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num_hi;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0: v = 34'sd843314856;  5'd1: v = 34'sd497837829;
      5'd2: v = 34'sd263043836;  5'd3: v = 34'sd133525158;
      5'd4: v = 34'sd67021686;   5'd5: v = 34'sd33543515;
      5'd6: v = 34'sd16775850;   5'd7: v = 34'sd8388437;
      5'd8: v = 34'sd4194282;    5'd9: v = 34'sd2097149;
      5'd10: v = 34'sd1048575;   5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;    5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;     5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;     5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;       5'd23: v = 34'sd127;
      5'd24: v = 34'sd63;        5'd25: v = 34'sd31;
      5'd26: v = 34'sd15;        5'd27: v = 34'sd7;
      5'd28: v = 34'sd3;         5'd29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

@@ hdl/stk_div.sv @@
// ============================================================================
// stk_div
// Restoring divider, one quotient bit per cycle: (num_hi << 30) / den.
// ============================================================================
`default_nettype none
module stk_div
  import stk_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [62:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [34:0] trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (req.start) begin
      num_nxt  = {1'b0, req.num_hi, 30'd0};
      rem_nxt  = '0;
      quot_nxt = '0;
      cnt_nxt  = 6'd63;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial   = {1'b0, rem_r, num_r[62]} - {2'b00, req.den};
      num_nxt = {num_r[61:0], 1'b0};
      if (!trial[34]) begin
        rem_nxt  = trial[32:0];
        quot_nxt = {quot_r[30:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[31:0], num_r[62]};
        quot_nxt = {quot_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  // quotient fits 31 bits since num <= den*2^30 when den != 0
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule
`default_nettype wire

@@ hdl/stabilizer_trajectory_kalman.sv @@
// ============================================================================
// stabilizer_trajectory_kalman
// Kalman trajectory smoother for video stabilization, one motion request
// per frame in, one corrected affine transform out.
// ============================================================================
// Input stream: in_tdata = {delta_angle, delta_y, delta_x}, in_tuser =
// motion_valid. Output stream: out_tdata = {shift_y, shift_x, sin, cos}.
// One request is taken when idle; the block drops in_tready until the
// result has been taken. Invalid frames go straight to ST_OUT, which posts
// the identity transform. The first valid frame only seeds the filter: path,
// 3 correction steps, 30 CORDIC steps, output. Later valid frames run per axis
// a setup step, a bit-serial gain divide, an update and a variance step, then
// the 3 correction steps and the 30-step CORDIC. Multipliers form the
// correction and variance products. The output register holds its value while
// out_tready is low; no new request is accepted until it is taken. Reset
// restores the register defaults and the zero trajectory; no clearing pass.
// APB: process_noise at 0x0, measurement_noise at 0x4.
// ============================================================================
`default_nettype none
module stabilizer_trajectory_kalman
  import stk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // delta_x, delta_y, delta_angle
  input  wire logic        in_tuser,   // motion_valid
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [127:0]     out_tdata,  // cos_term, sin_term, shift_x, shift_y
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic signed [PATH_WIDTH-1:0] PMAX = {1'b0, {(PATH_WIDTH-1){1'b1}}};
  localparam logic signed [PATH_WIDTH-1:0] PMIN = {1'b1, {(PATH_WIDTH-1){1'b0}}};

  state_t state_r, state_nxt;
  logic [31:0] q_r, r_r;
  logic signed [PATH_WIDTH-1:0] path_r [3];
  logic signed [PATH_WIDTH-1:0] smooth_r [3];
  logic [31:0] var_r [3];
  logic first_r;
  logic signed [31:0] delta_r [3];
  logic [1:0] ax_r;
  logic [32:0] pp_r;
  logic [31:0] k_r;
  logic [4:0] it_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic cneg_r;
  logic signed [31:0] res_r [3];
  logic [127:0] out_r;
  logic out_v_r;
  logic [1:0] ax_sel;

  div_req_t dreq;
  div_rsp_t drsp;
  stk_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? r_r : q_r;
  assign in_tready  = (state_r == ST_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= PROCESS_NOISE_RST;
      r_r <= MEASUREMENT_NOISE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_PROCESS_NOISE) q_r <= cfg_pwdata;
      else if (cfg_paddr[2] == REG_MEASUREMENT_NOISE) r_r <= cfg_pwdata;
    end
  end

  assign ax_sel = (ax_r == 2'd3) ? 2'd0 : ax_r;

  // shared arithmetic
  logic [32:0] p_sum;
  logic [31:0] p_sat;
  logic [PATH_WIDTH:0] mag;
  logic zge;
  logic [63:0] mul_a, mul_b;
  logic [63:0] corr;
  logic signed [PATH_WIDTH:0] dsm;
  logic signed [41:0] dcl;
  logic signed [42:0] csum;
  logic signed [31:0] csat;
  logic signed [33:0] sx_s, sy_s;
  logic signed [33:0] at;

  always_comb begin
    p_sum = {1'b0, var_r[ax_sel]} + {1'b0, q_r};
    p_sat = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    zge = path_r[ax_sel] >= smooth_r[ax_sel];
    mag = zge ? {path_r[ax_sel][PATH_WIDTH-1], path_r[ax_sel]} -
                {smooth_r[ax_sel][PATH_WIDTH-1], smooth_r[ax_sel]}
              : {smooth_r[ax_sel][PATH_WIDTH-1], smooth_r[ax_sel]} -
                {path_r[ax_sel][PATH_WIDTH-1], path_r[ax_sel]};
    mul_a = 64'(mag[PATH_WIDTH:30]) * 64'(k_r);
    mul_b = (64'(mag[29:0]) * 64'(k_r)) >> 30;
    corr  = mul_a + mul_b;
    dsm = {smooth_r[ax_sel][PATH_WIDTH-1], smooth_r[ax_sel]} -
          {path_r[ax_sel][PATH_WIDTH-1], path_r[ax_sel]};
    if (dsm > 49'sh100_0000_0000) dcl = 42'sh100_0000_0000;
    else if (dsm < -49'sh100_0000_0000) dcl = -42'sh100_0000_0000;
    else dcl = 42'(dsm);
    csum = 43'(dcl) + 43'(delta_r[ax_sel]);
    if (csum > 43'sh7FFF_FFFF) csat = 32'sh7FFF_FFFF;
    else if (csum < -43'sh8000_0000) csat = 32'sh8000_0000;
    else csat = csum[31:0];
    sx_s = cx_r >>> it_r;
    sy_s = cy_r >>> it_r;
    at = atan_lut(it_r);
  end

  logic [63:0] vprod;
  assign vprod = 64'({1'b0, ONE_Q30} - {1'b0, k_r}) * 64'(pp_r[31:0]);

  always_comb begin
    state_nxt = state_r;
    dreq.start = 1'b0;
    dreq.num_hi = p_sat;
    dreq.den = {1'b0, pp_r[31:0]} + {1'b0, r_r};
    unique case (state_r)
      ST_IDLE:   if (in_tvalid && in_tready) state_nxt = in_tuser ? ST_PATH : ST_OUT;
      ST_PATH:   state_nxt = first_r ? ST_CORR : ST_PREP;
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_DIV;
      ST_UPD:    state_nxt = ST_VAR;
      ST_VAR:    state_nxt = (ax_r == 2'd2) ? ST_CORR : ST_PREP;
      ST_CORR:   state_nxt = (ax_r == 2'd2) ? ST_CORDIC : ST_CORR;
      ST_CORDIC: state_nxt = (it_r == 5'(CORDIC_STEPS-1)) ? ST_OUT : ST_CORDIC;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_PREP) dreq.start = 1'b1;
    if (state_r == ST_DIV && drsp.done) state_nxt = ST_UPD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
      first_r <= 1'b1;
      ax_r <= '0;
      for (int i = 0; i < 3; i++) begin
        path_r[i] <= '0;
        smooth_r[i] <= '0;
        var_r[i] <= ONE_Q30;
      end
    end else begin
      state_r <= state_nxt;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          delta_r[0] <= in_tdata[31:0];
          delta_r[1] <= in_tdata[63:32];
          delta_r[2] <= in_tdata[95:64];
          ax_r <= '0;
          res_r[0] <= 32'sd0; res_r[1] <= 32'sd0; res_r[2] <= 32'sd0;
          cx_r <= {2'b00, ONE_Q30}; cy_r <= '0; cneg_r <= 1'b0;
        end
        ST_PATH: begin
          for (int i = 0; i < 3; i++) begin
            if (delta_r[i] > 0 && path_r[i] > PMAX - PATH_WIDTH'(delta_r[i]))
              path_r[i] <= PMAX;
            else if (delta_r[i] < 0 && path_r[i] < PMIN - PATH_WIDTH'(delta_r[i]))
              path_r[i] <= PMIN;
            else path_r[i] <= path_r[i] + PATH_WIDTH'(delta_r[i]);
          end
          if (first_r) begin
            for (int i = 0; i < 3; i++) begin
              smooth_r[i] <= '0;
              var_r[i] <= ONE_Q30;
            end
            first_r <= 1'b0;
          end
        end
        ST_PREP: pp_r <= {1'b0, p_sat};
        ST_DIV: if (drsp.done) k_r <= (dreq.den == 33'd0) ? 32'd0 : drsp.quot;
        ST_UPD: smooth_r[ax_sel] <= zge ? smooth_r[ax_sel] + PATH_WIDTH'(corr)
                                        : smooth_r[ax_sel] - PATH_WIDTH'(corr);
        ST_VAR: begin
          var_r[ax_sel] <= vprod[61:30];
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
        ST_CORR: begin
          res_r[ax_sel] <= csat;
          ax_r <= ax_r + 2'd1;
          if (ax_r == 2'd2) begin
            it_r <= '0;
            cx_r <= CORDIC_GAIN; cy_r <= '0;
            if (34'(csat) > HALF_PI_Q30) begin
              cz_r <= 34'(csat) - PI_Q30; cneg_r <= 1'b1;
            end else if (34'(csat) < -HALF_PI_Q30) begin
              cz_r <= 34'(csat) + PI_Q30; cneg_r <= 1'b1;
            end else begin
              cz_r <= 34'(csat); cneg_r <= 1'b0;
            end
          end
        end
        ST_CORDIC: begin
          it_r <= it_r + 5'd1;
          cz_r <= cz_r[33] ? cz_r + at : cz_r - at;
          if (it_r == 5'(CORDIC_STEPS-1) && cneg_r) begin
            if (!cz_r[33]) begin
              cx_r <= -(cx_r - sy_s); cy_r <= -(cy_r + sx_s);
            end else begin
              cx_r <= -(cx_r + sy_s); cy_r <= -(cy_r - sx_s);
            end
          end else if (!cz_r[33]) begin
            cx_r <= cx_r - sy_s; cy_r <= cy_r + sx_s;
          end else begin
            cx_r <= cx_r + sy_s; cy_r <= cy_r - sx_s;
          end
        end
        ST_OUT: begin
          out_v_r <= 1'b1;
          out_r <= {res_r[1], res_r[0],
                    (cy_r > 34'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                    (cy_r < -34'sh8000_0000) ? 32'h8000_0000 : cy_r[31:0],
                    (cx_r > 34'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                    (cx_r < -34'sh8000_0000) ? 32'h8000_0000 : cx_r[31:0]};
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> out_tvalid) else $error("result not posted");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("result changed");
endmodule
`default_nettype wire
